// ===== src/ssp_pkg.sv =====
// ssp_pkg: shared constants, types and helpers of the source sample projection block
`default_nettype none
package ssp_pkg;

   // number of source slots served by the order table
   localparam int SOURCE_SLOTS = 4;
   localparam int SLOT_LIMIT   = SOURCE_SLOTS - 1;

   // split position clamp range, unsigned Q0.16
   localparam logic [15:0] SPLIT_MIN = 16'd7;
   localparam logic [15:0] SPLIT_MAX = 16'd65529;

   // 1.0 in Q.28
   localparam logic signed [37:0] ONE_Q28 = 38'sd268435456;

   // register reset values
   localparam logic [16:0] LAYOUT_RESET = 17'd0;
   localparam logic [15:0] SPLIT_RESET  = 16'd32768;
   localparam logic [63:0] TABLE_RESET  = 64'd0;
   localparam logic [63:0] INV_RESET    = 64'h1000_1000_1000_1000;

   // register indexes
   typedef enum logic [2:0] {
      REG_LAYOUT    = 3'd0,
      REG_SPLIT     = 3'd1,
      REG_DISP_X    = 3'd2,
      REG_DISP_Y    = 3'd3,
      REG_INV_X     = 3'd4,
      REG_INV_Y     = 3'd5,
      REG_VIEW_U    = 3'd6,
      REG_VIEW_V    = 3'd7
   } ssp_reg_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [16:0] layout_control;
      logic [15:0] split_position;
      logic [63:0] disp_x;
      logic [63:0] disp_y;
      logic [63:0] inv_x;
      logic [63:0] inv_y;
      logic [63:0] view_u;
      logic [63:0] view_v;
   } ssp_cfg_type;

   // decode stage contents
   typedef struct packed {
      logic [15:0] local_u;
      logic [15:0] video_v;
      logic [1:0]  slot;
      logic        live;
   } ssp_s1_type;

   // per-stage advance enables
   typedef struct packed {
      logic s2;
      logic s3;
   } ssp_adv_type;

   // pick one signed Q4.12 lane of a packed table
   function automatic logic signed [15:0] lane_q412(input logic [63:0] tbl,
                                                   input logic [1:0] slot);
      return tbl[16 * slot +: 16];
   endfunction

endpackage
`default_nettype wire

// ===== src/ssp_if.sv =====
// ssp_if: request and response channel interfaces
`default_nettype none
interface ssp_req_if;
   import ssp_pkg::*;
   logic        valid;
   logic        ready;
   logic [15:0] video_u;
   logic [15:0] video_v;
   modport source (output valid, output video_u, output video_v, input ready);
   modport sink (input valid, input video_u, input video_v, output ready);
endinterface

interface ssp_rsp_if;
   import ssp_pkg::*;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [1:0]  source_index;
   logic [16:0] source_u;
   logic [16:0] source_v;
   modport source (output valid, output hit, output source_index,
                   output source_u, output source_v, input ready);
   modport sink (input valid, input hit, input source_index,
                 input source_u, input source_v, output ready);
endinterface
`default_nettype wire

// ===== src/ssp_csr.sv =====
// ssp_csr: APB-style configuration register file
`default_nettype none
module ssp_csr (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [5:0]          csr_paddr,
   input  wire logic [63:0]         csr_pwdata,
   output logic [63:0]              csr_prdata,
   output logic                     csr_pready,
   output ssp_pkg::ssp_cfg_type     cfg
);
   import ssp_pkg::*;

   ssp_cfg_type cfg_ff;
   ssp_cfg_type cfg_in;
   ssp_reg_type index;
   logic        write_en;

   assign index      = ssp_reg_type'(csr_paddr[5:3]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_LAYOUT: cfg_in.layout_control = csr_pwdata[16:0];
            REG_SPLIT:  cfg_in.split_position = csr_pwdata[15:0];
            REG_DISP_X: cfg_in.disp_x = csr_pwdata;
            REG_DISP_Y: cfg_in.disp_y = csr_pwdata;
            REG_INV_X:  cfg_in.inv_x = csr_pwdata;
            REG_INV_Y:  cfg_in.inv_y = csr_pwdata;
            REG_VIEW_U: cfg_in.view_u = csr_pwdata;
            REG_VIEW_V: cfg_in.view_v = csr_pwdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.layout_control <= LAYOUT_RESET;
         cfg_ff.split_position <= SPLIT_RESET;
         cfg_ff.disp_x         <= TABLE_RESET;
         cfg_ff.disp_y         <= TABLE_RESET;
         cfg_ff.inv_x          <= INV_RESET;
         cfg_ff.inv_y          <= INV_RESET;
         cfg_ff.view_u         <= TABLE_RESET;
         cfg_ff.view_v         <= TABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (index)
         REG_LAYOUT: csr_prdata = {47'd0, cfg_ff.layout_control};
         REG_SPLIT:  csr_prdata = {48'd0, cfg_ff.split_position};
         REG_DISP_X: csr_prdata = cfg_ff.disp_x;
         REG_DISP_Y: csr_prdata = cfg_ff.disp_y;
         REG_INV_X:  csr_prdata = cfg_ff.inv_x;
         REG_INV_Y:  csr_prdata = cfg_ff.inv_y;
         REG_VIEW_U: csr_prdata = cfg_ff.view_u;
         REG_VIEW_V: csr_prdata = cfg_ff.view_v;
         default:    csr_prdata = 64'd0;
      endcase
   end
endmodule
`default_nettype wire

// ===== src/ssp_decode.sv =====
// ssp_decode: display selection, local u and source slot lookup (stage 1)
`default_nettype none
module ssp_decode (
   input  wire logic                clock,
   input  wire logic                advance,
   input  wire ssp_pkg::ssp_cfg_type cfg,
   input  wire logic [15:0]         video_u,
   input  wire logic [15:0]         video_v,
   output ssp_pkg::ssp_s1_type      stage
);
   import ssp_pkg::*;

   ssp_s1_type  stage_ff;
   ssp_s1_type  stage_in;
   logic        split_mode;
   logic [2:0]  count;
   logic [2:0]  displays;
   logic [17:0] scaled;
   logic [15:0] split;
   logic [1:0]  disp;
   logic [1:0]  disp_cap;
   logic [1:0]  raw_slot;
   logic [1:0]  slot;
   logic [3:0]  present;

   assign split_mode = cfg.layout_control[1];
   assign present    = cfg.layout_control[16:13];
   assign scaled     = 18'(video_u) * 18'(displays);
   assign disp_cap   = 2'(displays - 3'd1);

   // display count and column or split selection
   always_comb begin
      count = cfg.layout_control[4:2];
      if (count < 3'd1) count = 3'd1;
      if (count > 3'd4) count = 3'd4;
      displays = (split_mode && count > 3'd2) ? 3'd2 : count;

      split = cfg.split_position;
      if (split < SPLIT_MIN) split = SPLIT_MIN;
      if (split > SPLIT_MAX) split = SPLIT_MAX;

      disp            = 2'd0;
      stage_in.local_u = video_u;
      if (!split_mode && displays > 3'd1) begin
         disp = (scaled[17:16] > disp_cap) ? disp_cap : scaled[17:16];
         stage_in.local_u = scaled[15:0];
      end else if (split_mode && displays > 3'd1) begin
         disp = (video_u < split) ? 2'd0 : 2'd1;
      end

      raw_slot = cfg.layout_control[5 + 2 * disp +: 2];
      slot     = (32'(raw_slot) > SLOT_LIMIT) ? 2'(SLOT_LIMIT) : raw_slot;

      stage_in.video_v = video_v;
      stage_in.slot    = slot;
      stage_in.live    = cfg.layout_control[0] && present[slot];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;
endmodule
`default_nettype wire

// ===== src/ssp_axis.sv =====
// ssp_axis: affine map of one axis, offset subtract and multiply stages
`default_nettype none
module ssp_axis (
   input  wire logic                 clock,
   input  wire ssp_pkg::ssp_adv_type adv,
   input  wire logic [15:0]          local_q16,
   input  wire logic signed [15:0]   offset,
   input  wire logic signed [15:0]   inv_size,
   input  wire logic signed [15:0]   view,
   output logic                      in_range,
   output logic [16:0]               coord
);
   import ssp_pkg::*;

   logic signed [20:0] diff_ff;
   logic signed [20:0] diff_in;
   logic signed [15:0] inv_ff;
   logic signed [15:0] view2_ff;
   logic signed [36:0] prod_ff;
   logic signed [36:0] prod_in;
   logic signed [15:0] view3_ff;
   logic signed [37:0] val;

   // local minus display offset raised to Q.16
   assign diff_in = $signed({5'd0, local_q16}) - $signed({offset[15], offset, 4'd0});

   // times inverse size gives Q.28
   assign prod_in = 37'(diff_ff) * 37'(inv_ff);

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         diff_ff  <= diff_in;
         inv_ff   <= inv_size;
         view2_ff <= view;
      end
      if (adv.s3) begin
         prod_ff  <= prod_in;
         view3_ff <= view2_ff;
      end
   end

   // view offset at Q.28, range test and floor to Q1.16
   assign val      = 38'(prod_ff) - $signed({{6{view3_ff[15]}}, view3_ff, 16'd0});
   assign in_range = !val[37] && (val <= ONE_Q28);
   assign coord    = val[28:12];
endmodule
`default_nettype wire

// ===== src/source_sample_projection_top.sv =====
// source_sample_projection_top: top level of the source sample projection block
//
// Maps an output-frame sample (video_u, video_v, unsigned Q0.16) to a source
// slot and a Q1.16 source texture coordinate. Words enter on req_word and
// leave on rsp_word, both valid/ready; a word moves when valid and ready are
// high at a rising clock edge. Every request gives exactly one response.
// Registers are written through the csr_ APB-style port, one 64-bit register
// per 8 bytes, and must only change while the pipeline is empty.
// The datapath has four register stages: decode, offset subtract, multiply,
// and a final add/compare feeding the output register. An accepted word
// passes decode, offset subtract, multiply and the output register in order,
// and one word is taken every cycle while the output is not stalled.
// Each stage holds its word while the one after it is full and blocked, so a
// stalled receiver fills the bubbles first and then backs up into req ready;
// nothing is dropped or duplicated.
// Reset clears all valid bits and returns the registers to their defaults.
`default_nettype none
module source_sample_projection_top (
   input  wire logic        clock,
   input  wire logic        reset,
   ssp_req_if.sink          req_word,
   ssp_rsp_if.source        rsp_word,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);
   import ssp_pkg::*;

   ssp_cfg_type cfg;
   ssp_s1_type  s1;
   ssp_adv_type adv;
   logic        adv1, adv4;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [1:0]  slot2_ff, slot3_ff;
   logic        live2_ff, live3_ff;
   logic        in_x, in_y;
   logic [16:0] coord_x, coord_y;
   logic        hit_ff, hit_in;
   logic [1:0]  index_ff;
   logic [16:0] su_ff, sv_ff;

   // per-stage advance chain
   assign adv4   = !v4_ff || rsp_word.ready;
   assign adv.s3 = !v3_ff || adv4;
   assign adv.s2 = !v2_ff || adv.s3;
   assign adv1   = !v1_ff || adv.s2;
   assign req_word.ready = adv1;

   ssp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ssp_decode u_decode (
      .clock   (clock),
      .advance (adv1),
      .cfg     (cfg),
      .video_u (req_word.video_u),
      .video_v (req_word.video_v),
      .stage   (s1)
   );

   ssp_axis u_axis_x (
      .clock     (clock),
      .adv       (adv),
      .local_q16 (s1.local_u),
      .offset    (lane_q412(cfg.disp_x, s1.slot)),
      .inv_size  (lane_q412(cfg.inv_x, s1.slot)),
      .view      (lane_q412(cfg.view_u, s1.slot)),
      .in_range  (in_x),
      .coord     (coord_x)
   );

   ssp_axis u_axis_y (
      .clock     (clock),
      .adv       (adv),
      .local_q16 (s1.video_v),
      .offset    (lane_q412(cfg.disp_y, s1.slot)),
      .inv_size  (lane_q412(cfg.inv_y, s1.slot)),
      .view      (lane_q412(cfg.view_v, s1.slot)),
      .in_range  (in_y),
      .coord     (coord_y)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1)   v1_ff <= req_word.valid;
         if (adv.s2) v2_ff <= v1_ff;
         if (adv.s3) v3_ff <= v2_ff;
         if (adv4)   v4_ff <= v3_ff;
      end
   end

   // slot and presence follow the datapath
   always_ff @(posedge clock) begin
      if (adv.s2) begin
         slot2_ff <= s1.slot;
         live2_ff <= s1.live;
      end
      if (adv.s3) begin
         slot3_ff <= slot2_ff;
         live3_ff <= live2_ff;
      end
   end

   // output register, zeros on a miss
   assign hit_in = live3_ff && in_x && in_y;

   always_ff @(posedge clock) begin
      if (adv4) begin
         hit_ff   <= hit_in;
         index_ff <= hit_in ? slot3_ff : 2'd0;
         su_ff    <= hit_in ? coord_x : 17'd0;
         sv_ff    <= hit_in ? coord_y : 17'd0;
      end
   end

   assign rsp_word.valid        = v4_ff;
   assign rsp_word.hit          = hit_ff;
   assign rsp_word.source_index = index_ff;
   assign rsp_word.source_u     = su_ff;
   assign rsp_word.source_v     = sv_ff;
endmodule
`default_nettype wire

// ===== src/ssp_checker.sv =====
// ssp_port_checker: port-level checks of the source sample projection block
`default_nettype none
module ssp_port_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_hit,
   input wire logic [1:0]  rsp_source_index,
   input wire logic [16:0] rsp_source_u,
   input wire logic [16:0] rsp_source_v,
   input wire logic        csr_pready
);
   // no response right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds its word
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_source_u) && $stable(rsp_source_v))
      else $error("stalled response changed");

   // a miss carries all zeros
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_source_index == 2'd0
         && rsp_source_u == 17'd0 && rsp_source_v == 17'd0)
      else $error("miss with nonzero fields");

   // a hit lies within [0,1]
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_source_u <= 17'd65536
         && rsp_source_v <= 17'd65536)
      else $error("hit coordinate above 1.0");

   // register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");
endmodule

bind source_sample_projection_top ssp_port_checker u_ssp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_word.valid),
   .rsp_ready        (rsp_word.ready),
   .rsp_hit          (rsp_word.hit),
   .rsp_source_index (rsp_word.source_index),
   .rsp_source_u     (rsp_word.source_u),
   .rsp_source_v     (rsp_word.source_v),
   .csr_pready       (csr_pready)
);
`default_nettype wire

// ===== tb/ssp_checker.sv =====
// ssp_checker: watches the channels and the register port, predicts every response word and compares it
module ssp_checker
   import ssp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   ssp_req_if               req_mon,
   ssp_rsp_if               rsp_mon,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic        csr_pready,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output int               fail_count,
   output int               outstanding
);

   typedef struct packed {
      logic        hit;
      logic [1:0]  source_index;
      logic [16:0] source_u;
      logic [16:0] source_v;
   } projection_word_t;

   // register copy kept in step with the port writes
   ssp_cfg_type      active_cfg;
   projection_word_t expected_projections[$];

   // signed q4.12 lane of a packed register, slot 0 in the low bits
   function automatic logic signed [15:0] slot_lane(input logic [63:0] packed_lanes,
                                                    input logic [1:0] slot);
      return 16'(packed_lanes >> (16 * slot));
   endfunction

   // affine map of one axis; exact q.28 range test, result floored to q1.16
   function automatic logic axis_in_range(input longint coord,
                                          input logic signed [15:0] offset,
                                          input logic signed [15:0] inv_size,
                                          input logic signed [15:0] view,
                                          output logic [16:0] q16);
      longint exact;
      exact = (coord - longint'(offset) * 16) * longint'(inv_size)
              - longint'(view) * 65536;
      q16 = 17'(exact >>> 12);
      return (exact >= 0) && (exact <= longint'(ONE_Q28));
   endfunction

   // projection of one sample under the given register set
   function automatic projection_word_t project_sample(input ssp_cfg_type cfg,
                                                       input logic [15:0] u,
                                                       input logic [15:0] v);
      projection_word_t result;
      int unsigned      count;
      int unsigned      displays;
      int unsigned      disp;
      logic [31:0]      scaled;
      logic [15:0]      local_u;
      logic [15:0]      split;
      logic [1:0]       slot;
      logic [16:0]      su;
      logic [16:0]      sv;
      result = '0;
      if (!cfg.layout_control[0]) return result;

      // track count clamp, split screen shows at most two displays
      count = cfg.layout_control[4:2];
      if (count < 1) count = 1;
      if (count > 4) count = 4;
      displays = (cfg.layout_control[1] && count > 2) ? 2 : count;

      // display choice and local u
      disp = 0;
      local_u = u;
      if (!cfg.layout_control[1] && displays > 1) begin
         scaled = 32'(u) * displays;
         disp = scaled >> 16;
         if (disp > displays - 1) disp = displays - 1;
         local_u = scaled[15:0];
      end else if (cfg.layout_control[1] && displays > 1) begin
         split = cfg.split_position;
         if (split < SPLIT_MIN) split = SPLIT_MIN;
         if (split > SPLIT_MAX) split = SPLIT_MAX;
         disp = (u < split) ? 0 : 1;
      end

      // order table and presence
      slot = cfg.layout_control[5 + 2 * disp +: 2];
      if (!cfg.layout_control[13 + slot]) return result;

      if (!axis_in_range(longint'(local_u), slot_lane(cfg.disp_x, slot),
                         slot_lane(cfg.inv_x, slot), slot_lane(cfg.view_u, slot), su))
         return result;
      if (!axis_in_range(longint'(v), slot_lane(cfg.disp_y, slot),
                         slot_lane(cfg.inv_y, slot), slot_lane(cfg.view_v, slot), sv))
         return result;

      result.hit = 1'b1;
      result.source_index = slot;
      result.source_u = su;
      result.source_v = sv;
      return result;
   endfunction

   function automatic int field_differs(input string name, input int unsigned want,
                                        input int unsigned got);
      if (want == got) return 0;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      projection_word_t want;
      int               errs;
      errs = 0;
      if (reset) begin
         active_cfg.layout_control <= LAYOUT_RESET;
         active_cfg.split_position <= SPLIT_RESET;
         active_cfg.disp_x <= TABLE_RESET;
         active_cfg.disp_y <= TABLE_RESET;
         active_cfg.inv_x <= INV_RESET;
         active_cfg.inv_y <= INV_RESET;
         active_cfg.view_u <= TABLE_RESET;
         active_cfg.view_v <= TABLE_RESET;
         expected_projections.delete();
         fail_count <= 0;
      end else begin
         // register writes, upper bits beyond the register width dropped
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (ssp_reg_type'(csr_paddr[5:3]))
               REG_LAYOUT: active_cfg.layout_control <= csr_pwdata[16:0];
               REG_SPLIT:  active_cfg.split_position <= csr_pwdata[15:0];
               REG_DISP_X: active_cfg.disp_x <= csr_pwdata;
               REG_DISP_Y: active_cfg.disp_y <= csr_pwdata;
               REG_INV_X:  active_cfg.inv_x <= csr_pwdata;
               REG_INV_Y:  active_cfg.inv_y <= csr_pwdata;
               REG_VIEW_U: active_cfg.view_u <= csr_pwdata;
               REG_VIEW_V: active_cfg.view_v <= csr_pwdata;
               default: ;
            endcase
         end

         // accepted request word
         if (req_mon.valid && req_mon.ready)
            expected_projections.push_back(
               project_sample(active_cfg, req_mon.video_u, req_mon.video_v));

         // accepted response word against the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_projections.size() == 0) begin
               $error("response word with no expectation pending");
               errs++;
            end else begin
               want = expected_projections.pop_front();
               errs += field_differs("hit", want.hit, rsp_mon.hit);
               errs += field_differs("source_index", want.source_index,
                                     rsp_mon.source_index);
               errs += field_differs("source_u", want.source_u, rsp_mon.source_u);
               errs += field_differs("source_v", want.source_v, rsp_mon.source_v);
            end
         end
         fail_count <= fail_count + errs;
      end
      outstanding <= expected_projections.size();
   end

endmodule

// ===== tb/tb_source_sample_projection_top.sv =====
// tb_source_sample_projection_top: clock, reset, stimulus and verdict for the projection block
module tb_source_sample_projection_top;
   import ssp_pkg::*;

   localparam int PIPE_LATENCY     = 3;
   localparam int RANDOM_PHASES    = 12;
   localparam int WORDS_PER_PHASE  = 155;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT      = 600000;

   typedef enum int {RSP_ALWAYS, RSP_COIN, RSP_SPARSE, RSP_PATTERN} ready_mode_t;
   typedef enum int {LANE_OFFSET, LANE_INVERSE, LANE_VIEW} lane_kind_t;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          outstanding;
   int          cycle_count = 0;
   int          hold_requests = 0;
   int          holds_served = 0;
   int          burst_left = 0;

   ssp_req_if req_word();
   ssp_rsp_if rsp_word();

   source_sample_projection_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_word),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ssp_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_word),
      .rsp_mon     (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: stretches of ready patterns, plus long hold-offs on request
   initial begin : rsp_side
      ready_mode_t mode;
      int          stretch_left;
      int          hold_left;
      int          tick;
      mode = RSP_ALWAYS;
      stretch_left = 0;
      hold_left = 0;
      tick = 0;
      rsp_word.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (stretch_left == 0) begin
            mode = ready_mode_t'($urandom_range(0, 3));
            stretch_left = $urandom_range(8, 160);
         end
         stretch_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_word.ready <= 1'b0;
         end else begin
            case (mode)
               RSP_ALWAYS: rsp_word.ready <= 1'b1;
               RSP_COIN:   rsp_word.ready <= 1'($urandom_range(0, 1));
               RSP_SPARSE: rsp_word.ready <= ($urandom_range(0, 3) == 0);
               default:    rsp_word.ready <= (tick % 5 != 0);
            endcase
         end
      end
   end

   function automatic logic [16:0] make_layout(input logic [3:0] present,
                                               input logic [7:0] order,
                                               input logic [2:0] count,
                                               input logic split_mode,
                                               input logic enable);
      return {present, order, count, split_mode, enable};
   endfunction

   // mostly plausible lanes so that many samples land inside the source
   function automatic logic [63:0] random_lanes(input lane_kind_t kind);
      logic [63:0] lanes;
      int          s;
      for (int i = 0; i < 4; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            s = $urandom;
         end else begin
            case (kind)
               LANE_OFFSET:  s = int'($urandom_range(0, 1024)) - 512;
               LANE_INVERSE: s = $urandom_range(3072, 8192);
               default:      s = int'($urandom_range(0, 512)) - 256;
            endcase
         end
         lanes[16 * i +: 16] = s[15:0];
      end
      return lanes;
   endfunction

   function automatic logic [15:0] random_coord();
      if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      return 16'($urandom);
   endfunction

   task automatic csr_write(input ssp_reg_type idx, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_registers(input logic [16:0] layout, input logic [15:0] split,
                                  input logic [63:0] disp_x, input logic [63:0] disp_y,
                                  input logic [63:0] inv_x, input logic [63:0] inv_y,
                                  input logic [63:0] view_u, input logic [63:0] view_v);
      csr_write(REG_LAYOUT, 64'(layout));
      csr_write(REG_SPLIT, 64'(split));
      csr_write(REG_DISP_X, disp_x);
      csr_write(REG_DISP_Y, disp_y);
      csr_write(REG_INV_X, inv_x);
      csr_write(REG_INV_Y, inv_y);
      csr_write(REG_VIEW_U, view_u);
      csr_write(REG_VIEW_V, view_v);
   endtask

   // offer one sample word and wait for it to be taken
   task automatic send_sample(input logic [15:0] u, input logic [15:0] v);
      req_word.valid <= 1'b1;
      req_word.video_u <= u;
      req_word.video_v <= v;
      @(posedge clock);
      while (!req_word.ready) @(posedge clock);
   endtask

   // bursts of random length with random gaps between them
   task automatic sender_pause();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_word.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_paced(input logic [15:0] u, input logic [15:0] v);
      send_sample(u, v);
      sender_pause();
   endtask

   // stop offering and wait until every response word is back
   task automatic drain_pipeline();
      req_word.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // stimulus and verdict
   initial begin
      logic [15:0] split_pick [6];
      split_pick = '{16'd0, 16'd6, 16'd7, 16'd65529, 16'd65530, 16'd65535};
      reset <= 1'b1;
      req_word.valid <= 1'b0;
      req_word.video_u <= '0;
      req_word.video_v <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled after reset
      send_paced(16'h0000, 16'h0000);
      send_paced(16'hFFFF, 16'hFFFF);

      // single display, identity map, track count field zero
      drain_pipeline();
      csr_write(REG_LAYOUT, 64'(make_layout(4'hF, 8'h00, 3'd0, 1'b0, 1'b1)));
      send_paced(16'h0000, 16'h0000);
      send_paced(16'hFFFF, 16'hFFFF);
      send_paced(16'h8000, 16'h0001);

      // split screen, count above two, split position clamped low then high
      drain_pipeline();
      csr_write(REG_LAYOUT, 64'(make_layout(4'hF, 8'h06, 3'd7, 1'b1, 1'b1)));
      csr_write(REG_SPLIT, 64'd0);
      send_paced(16'd6, 16'd100);
      send_paced(16'd7, 16'd100);
      drain_pipeline();
      csr_write(REG_SPLIT, 64'hFFFF);
      send_paced(16'd65528, 16'd200);
      send_paced(16'd65529, 16'd200);

      // four columns with two sources absent, then three columns at the border
      drain_pipeline();
      csr_write(REG_LAYOUT, 64'(make_layout(4'b0101, 8'hE4, 3'd6, 1'b0, 1'b1)));
      send_paced(16'd0, 16'd500);
      send_paced(16'd16384, 16'd500);
      send_paced(16'd32768, 16'd500);
      send_paced(16'd65535, 16'd500);
      drain_pipeline();
      csr_write(REG_LAYOUT, 64'(make_layout(4'hF, 8'hE4, 3'd3, 1'b0, 1'b1)));
      send_paced(16'd21845, 16'd700);
      send_paced(16'd21846, 16'd700);

      // exact 1.0 and exact 0 edges of the hit window
      drain_pipeline();
      csr_write(REG_LAYOUT, 64'(make_layout(4'hF, 8'h00, 3'd1, 1'b0, 1'b1)));
      csr_write(REG_INV_X, {4{16'h2000}});
      csr_write(REG_DISP_Y, {4{16'h0001}});
      send_paced(16'd32768, 16'd16);
      send_paced(16'd32769, 16'd16);
      send_paced(16'd0, 16'd15);
      send_paced(16'd0, 16'd16);

      // random phases, the first three at register extremes
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain_pipeline();
         case (ph)
            0: write_registers(17'h1FFFF, 16'hFFFF, '1, '1, '1, '1, '1, '1);
            1: write_registers(make_layout(4'hF, 8'($urandom), 3'($urandom),
                                           1'($urandom), 1'b1),
                               16'h0000, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}},
                               {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
            2: write_registers(make_layout(4'hF, 8'($urandom), 3'($urandom),
                                           1'($urandom), 1'b1),
                               16'hFFFF, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
                               {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
            default: write_registers(
               make_layout($urandom_range(0, 1) ? 4'hF : 4'($urandom), 8'($urandom),
                           3'($urandom), 1'($urandom), ($urandom_range(0, 7) != 0)),
               ($urandom_range(0, 3) == 0) ? split_pick[$urandom_range(0, 5)]
                                           : 16'($urandom),
               random_lanes(LANE_OFFSET), random_lanes(LANE_OFFSET),
               random_lanes(LANE_INVERSE), random_lanes(LANE_INVERSE),
               random_lanes(LANE_VIEW), random_lanes(LANE_VIEW));
         endcase
         // long receiver hold-off while samples keep coming
         if (ph == 4 || ph == 9) hold_requests++;
         repeat (WORDS_PER_PHASE) send_paced(random_coord(), random_coord());
      end

      drain_pipeline();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
